@@ rtl/core/bwsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bwsm_pkg
// Shared widths, defaults, types and the ASCII upper-case function for the
// blocked word stream matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package bwsm_pkg;

    localparam int BYTE_W           = 8;
    localparam int SLOT_W           = 64;
    localparam int SLOT_COUNT       = 8;
    localparam int IDX_W            = 3;
    localparam int HIST_DEPTH       = 7;
    localparam int NUM_WORDS_DEF    = 8;
    localparam int WORD_BYTES_DEF   = 8;

    typedef logic [BYTE_W-1:0]                  byte_t;
    typedef logic [SLOT_W-1:0]                  slot_t;
    typedef logic [HIST_DEPTH-1:0][BYTE_W-1:0]  hist_t;

    localparam byte_t LOWER_A   = 8'h61;
    localparam byte_t LOWER_Z   = 8'h7A;
    localparam byte_t CASE_DIFF = 8'h20;

    function automatic byte_t upcase(input byte_t c);
        byte_t r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bwsm_msg_if.sv @@
// ----------------------------------------------------------------------------
// bwsm_msg_if
// Message word channel: one raw byte, a present flag and an end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwsm_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output msg_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input msg_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bwsm_verdict_if.sv @@
// ----------------------------------------------------------------------------
// bwsm_verdict_if
// Verdict channel: one drop/pass word per message.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwsm_verdict_if;
    logic valid;
    logic ready;
    logic drop_verdict;

    modport source (output valid, output drop_verdict, input ready);
    modport sink   (input valid, input drop_verdict, output ready);
endinterface

`default_nettype wire

@@ rtl/core/blocked_word_stream_matcher.sv @@
// ----------------------------------------------------------------------------
// blocked_word_stream_matcher
// Streams a message a byte at a time, matches the upper-cased byte window
// against the blocked words and gives one drop/pass verdict per message.
//
//   channel   dir   handshake           payload
//   msg       in    valid/ready         msg_byte, byte_present, end_of_message
//   verdict   out   valid/ready         drop_verdict
//   cfg       in    cfg_we (no stall)   cfg_index, cfg_data
//
// One word per cycle sustained while msg is not stalled; a verdict passes the
// input register, then match logic into the verdict register.
// msg stalls only when an end word waits on a verdict register still full.
// Reset clears the word slots, history and message flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module blocked_word_stream_matcher
    import bwsm_pkg::*;
#(
    parameter int NUM_WORDS  = NUM_WORDS_DEF,
    parameter int WORD_BYTES = WORD_BYTES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    bwsm_msg_if.sink                msg,
    bwsm_verdict_if.source          verdict,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [SLOT_W-1:0]  cfg_data
);

    logic [NUM_WORDS-1:0][SLOT_W-1:0] slots;

    logic   s1_valid_reg;
    byte_t  s1_byte_reg;
    logic   s1_present_reg;
    logic   s1_eom_reg;

    hist_t  hist_reg;
    hist_t  hist_next;
    logic   hit_seen_reg;
    logic   hit_seen_next;
    logic   text_ended_reg;
    logic   text_ended_next;

    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_drop_reg;

    byte_t  cur;
    logic   hit;
    logic   take;
    logic   s1_advance;
    logic   s1_fire;
    logic   in_ready;
    logic   verdict_now;

    bwsm_cfg_regs #(
        .NUM_WORDS (NUM_WORDS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .slots     (slots)
    );

    assign cur = upcase(s1_byte_reg);

    bwsm_match #(
        .NUM_WORDS  (NUM_WORDS),
        .WORD_BYTES (WORD_BYTES)
    ) u_match (
        .slots (slots),
        .cur   (cur),
        .hist  (hist_reg),
        .hit   (hit)
    );

    assign s1_advance = !s1_eom_reg || !out_valid_reg || verdict.ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign msg.ready  = in_ready;

    assign take        = s1_present_reg && !text_ended_reg && (s1_byte_reg != '0);
    assign verdict_now = hit_seen_reg || (take && hit);

    always_comb
    begin
        hist_next       = hist_reg;
        hit_seen_next   = hit_seen_reg;
        text_ended_next = text_ended_reg;
        if (s1_fire)
        begin
            if (s1_eom_reg)
            begin
                hist_next       = '0;
                hit_seen_next   = 1'b0;
                text_ended_next = 1'b0;
            end
            else if (take)
            begin
                hist_next     = {hist_reg[HIST_DEPTH-2:0], cur};
                hit_seen_next = verdict_now;
            end
            else if (s1_present_reg && !text_ended_reg)
            begin
                text_ended_next = 1'b1;
            end
        end
    end

    assign out_valid_next = (out_valid_reg && !verdict.ready) || (s1_fire && s1_eom_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            hist_reg       <= '0;
            hit_seen_reg   <= 1'b0;
            text_ended_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= msg.valid;
            end
            hist_reg       <= hist_next;
            hit_seen_reg   <= hit_seen_next;
            text_ended_reg <= text_ended_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && msg.valid)
        begin
            s1_byte_reg    <= msg.msg_byte;
            s1_present_reg <= msg.byte_present;
            s1_eom_reg     <= msg.end_of_message;
        end
        if (s1_fire && s1_eom_reg)
        begin
            out_drop_reg <= verdict_now;
        end
    end

    assign verdict.valid        = out_valid_reg;
    assign verdict.drop_verdict = out_drop_reg;

endmodule

`default_nettype wire

@@ rtl/core/bwsm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bwsm_cfg_regs
// Blocked word slot registers, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bwsm_cfg_regs
    import bwsm_pkg::*;
#(
    parameter int NUM_WORDS = NUM_WORDS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [IDX_W-1:0]         cfg_index,
    input  wire logic [SLOT_W-1:0]        cfg_data,
    output      logic [NUM_WORDS-1:0][SLOT_W-1:0] slots
);

    genvar s;
    generate
        for (s = 0; s < NUM_WORDS; s++)
        begin : g_slot
            slot_t slot_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    slot_reg <= '0;
                end
                else if (cfg_we && cfg_index == IDX_W'(s))
                begin
                    slot_reg <= cfg_data;
                end
            end

            assign slots[s] = slot_reg;
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/core/bwsm_match.sv @@
// ----------------------------------------------------------------------------
// bwsm_match
// Compares the byte window ending at the current byte against every blocked
// word, all slots and all word lengths in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module bwsm_match
    import bwsm_pkg::*;
#(
    parameter int NUM_WORDS  = NUM_WORDS_DEF,
    parameter int WORD_BYTES = WORD_BYTES_DEF
)
(
    input  wire logic [NUM_WORDS-1:0][SLOT_W-1:0] slots,
    input  wire logic [BYTE_W-1:0]                cur,
    input  wire hist_t                            hist,
    output      logic                             hit
);

    logic [WORD_BYTES-1:0][BYTE_W-1:0]                      win;
    logic [NUM_WORDS-1:0][WORD_BYTES-1:0][BYTE_W-1:0]       wb;
    logic [NUM_WORDS-1:0][WORD_BYTES-1:0][WORD_BYTES-1:0]   byte_ok;
    logic [NUM_WORDS-1:0][WORD_BYTES-1:0]                   tail_ok;
    logic [NUM_WORDS-1:0][WORD_BYTES-1:0]                   len_hit;
    logic [NUM_WORDS-1:0]                                   slot_hit;

    genvar s, l, k;
    generate
        assign win[0] = cur;
        for (l = 1; l < WORD_BYTES; l++)
        begin : g_win
            assign win[l] = hist[l-1];
        end

        for (s = 0; s < NUM_WORDS; s++)
        begin : g_slot
            for (k = 0; k < WORD_BYTES; k++)
            begin : g_wb
                assign wb[s][k] = upcase(slots[s][BYTE_W*k +: BYTE_W]);
            end

            // word length l+1: bytes 0..l nonzero and equal, byte l+1 zero
            for (l = 0; l < WORD_BYTES; l++)
            begin : g_len
                for (k = 0; k < WORD_BYTES; k++)
                begin : g_cmp
                    if (k > l)
                    begin : g_pad
                        assign byte_ok[s][l][k] = 1'b1;
                    end
                    else
                    begin : g_eq
                        assign byte_ok[s][l][k] = (wb[s][k] != '0) &&
                                                  (wb[s][k] == win[l-k]);
                    end
                end

                if (l == WORD_BYTES-1)
                begin : g_full
                    assign tail_ok[s][l] = 1'b1;
                end
                else
                begin : g_short
                    assign tail_ok[s][l] = (wb[s][l+1] == '0);
                end

                assign len_hit[s][l] = (&byte_ok[s][l]) && tail_ok[s][l];
            end

            assign slot_hit[s] = |len_hit[s];
        end
    endgenerate

    assign hit = |slot_hit;

endmodule

`default_nettype wire

@@ verif/blocked_word_stream_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// blocked_word_stream_matcher_tb
// Streams messages through the matcher and checks every drop/pass verdict
// against a local model of the byte window, the word slots and the message
// flags. A short directed run covers the corner cases. Randomized phases follow,
// each with its own slot setting and, but for one quiet phase, random idling on
// both channels. One phase holds the verdict side off to stall the message side.
// ----------------------------------------------------------------------------
module blocked_word_stream_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bwsm_pkg::*;

    localparam int SLOT_BYTES     = SLOT_W / BYTE_W;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 150;
    localparam int HOLD_PHASE     = 5;
    localparam int QUIET_PHASE    = 3;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_PAD      = 6;
    localparam int CYCLE_LIMIT    = 500_000;

    typedef struct {
        byte_t raw;
        bit    present;
    } msg_item_t;

    class verdict_board;
        slot_t slots [SLOT_COUNT];
        byte_t history [HIST_DEPTH];
        bit    hit_seen;
        bit    text_ended;
        bit    due_verdicts [$];
        int    errors;

        function new();
            foreach (slots[i])
            begin
                slots[i] = '0;
            end
            clear_message();
            errors = 0;
        endfunction

        function void clear_message();
            foreach (history[i])
            begin
                history[i] = '0;
            end
            hit_seen   = 1'b0;
            text_ended = 1'b0;
        endfunction

        function void write_slot(int idx, slot_t value);
            if (idx < SLOT_COUNT)
            begin
                slots[idx] = value;
            end
        endfunction

        function byte_t to_caps(byte_t c);
            byte_t r;
            r = c;
            if (c >= 8'h61 && c <= 8'h7A)
            begin
                r = c & 8'hDF;
            end
            return r;
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction

        // does any active word end exactly at the current byte
        function bit window_hits(byte_t cur);
            int    len;
            bit    ok;
            byte_t seen;
            for (int s = 0; s < NUM_WORDS_DEF; s++)
            begin
                len = 0;
                while (len < WORD_BYTES_DEF && slots[s][8*len +: 8] != 8'h00)
                begin
                    len++;
                end
                ok = (len != 0);
                for (int k = 0; k < len; k++)
                begin
                    seen = (k == len - 1) ? cur : history[len - 2 - k];
                    if (to_caps(slots[s][8*k +: 8]) != seen)
                    begin
                        ok = 1'b0;
                    end
                end
                if (ok)
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_word(byte_t raw, bit present, bit last);
            byte_t cur;
            if (present && !text_ended)
            begin
                if (raw == 8'h00)
                begin
                    text_ended = 1'b1;
                end
                else
                begin
                    cur = to_caps(raw);
                    if (window_hits(cur))
                    begin
                        hit_seen = 1'b1;
                    end
                    for (int i = HIST_DEPTH - 1; i > 0; i--)
                    begin
                        history[i] = history[i - 1];
                    end
                    history[0] = cur;
                end
            end
            if (last)
            begin
                due_verdicts.push_back(hit_seen);
                clear_message();
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_verdict(logic drop);
            bit want;
            if (due_verdicts.size() == 0)
            begin
                report($sformatf("verdict %b with no message pending", drop));
                return;
            end
            want = due_verdicts.pop_front();
            if (drop !== want)
            begin
                report($sformatf("drop_verdict %b, expected %b", drop, want));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [SLOT_W-1:0]    cfg_data;

    bwsm_msg_if           msg ();
    bwsm_verdict_if       verdict ();

    verdict_board         board = new();
    int                   words_sent = 0;
    int                   cycles = 0;
    int                   hold_token = 0;
    bit                   tx_gaps = 1'b1;
    bit                   rx_gaps = 1'b1;

    blocked_word_stream_matcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .verdict   (verdict),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL blocked_word_stream_matcher");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && msg.valid === 1'b1 && msg.ready === 1'b1)
        begin
            board.note_word(msg.msg_byte, msg.byte_present, msg.end_of_message);
        end
        if (rst_n && verdict.valid === 1'b1 && verdict.ready === 1'b1)
        begin
            board.check_verdict(verdict.drop_verdict);
        end
    end

    // verdict side: random stalls, plus one long hold on request
    initial
    begin
        int hold_left;
        int hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        verdict.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_taken)
            begin
                hold_taken = hold_token;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                verdict.ready <= 1'b0;
            end
            else
            begin
                verdict.ready <= !(rx_gaps && $urandom_range(99) < 16);
            end
        end
    end

    function automatic byte_t alpha_byte();
        byte_t b;
        b = 8'h41 + byte_t'($urandom_range(2));
        if ($urandom_range(1))
        begin
            b = b | CASE_DIFF;
        end
        return b;
    endfunction

    function automatic slot_t pack_text(string s);
        slot_t v;
        v = '0;
        for (int k = 0; k < s.len() && k < SLOT_BYTES; k++)
        begin
            v[8*k +: 8] = s[k];
        end
        return v;
    endfunction

    function automatic slot_t make_slot();
        slot_t v;
        int    r;
        int    len;
        v = '0;
        r = $urandom_range(99);
        if (r < 10)
        begin
            v = '0;
        end
        else if (r < 18)
        begin
            v = {$urandom, $urandom};
        end
        else if (r < 24)
        begin
            v = {$urandom, $urandom} & ~slot_t'(8'hFF);
        end
        else if (r < 28)
        begin
            v = '1;
        end
        else
        begin
            len = ($urandom_range(3) == 0) ? $urandom_range(4, SLOT_BYTES)
                                           : $urandom_range(1, 3);
            // junk past the terminator must be ignored
            if (len < SLOT_BYTES && $urandom_range(2) == 0)
            begin
                v = {$urandom, $urandom};
            end
            for (int k = 0; k < SLOT_BYTES; k++)
            begin
                if (k < len)
                begin
                    v[8*k +: 8] = alpha_byte();
                end
                else if (k == len)
                begin
                    v[8*k +: 8] = 8'h00;
                end
            end
        end
        return v;
    endfunction

    task automatic write_slots(slot_t values [SLOT_COUNT]);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[IDX_W-1:0];
            cfg_data  <= values[i];
            @(posedge clk);
            board.write_slot(i, values[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(byte_t raw, bit present, bit last);
        while (tx_gaps && $urandom_range(99) < 16)
        begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid          <= 1'b1;
        msg.msg_byte       <= raw;
        msg.byte_present   <= present;
        msg.end_of_message <= last;
        do
            @(posedge clk);
        while (msg.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic send_text(string s, bit last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], 1'b1, last && i == s.len() - 1);
        end
    endtask

    // mostly alphabet bytes and embedded slot words, some noise, zeros, gaps
    task automatic send_message(int max_len);
        msg_item_t items [$];
        int        len;
        int        r;
        int        s;
        int        wl;
        byte_t     b;
        bit        split_end;
        len = $urandom_range(0, max_len);
        while (items.size() < len)
        begin
            r = $urandom_range(99);
            if (r < 25)
            begin
                s  = $urandom_range(SLOT_COUNT - 1);
                wl = 0;
                while (wl < WORD_BYTES_DEF && board.slots[s][8*wl +: 8] != 8'h00)
                begin
                    b = board.slots[s][8*wl +: 8];
                    if ((b | CASE_DIFF) >= 8'h61 && (b | CASE_DIFF) <= 8'h7A
                        && $urandom_range(1))
                    begin
                        b = b ^ CASE_DIFF;
                    end
                    items.push_back(msg_item_t'{b, 1'b1});
                    wl++;
                end
            end
            else if (r < 85)
            begin
                items.push_back(msg_item_t'{alpha_byte(), 1'b1});
            end
            else if (r < 92)
            begin
                items.push_back(msg_item_t'{byte_t'($urandom_range(1, 255)), 1'b1});
            end
            else if (r < 95)
            begin
                items.push_back(msg_item_t'{8'h00, 1'b1});
            end
            else
            begin
                items.push_back(msg_item_t'{byte_t'($urandom_range(255)), 1'b0});
            end
        end
        split_end = (items.size() == 0) || ($urandom_range(99) < 30);
        foreach (items[i])
        begin
            send_word(items[i].raw, items[i].present,
                      !split_end && i == items.size() - 1);
        end
        if (split_end)
        begin
            send_word(byte_t'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    task automatic settle();
        msg.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    initial
    begin
        slot_t setting [SLOT_COUNT];
        int    phase_start;
        msg.valid          <= 1'b0;
        msg.msg_byte       <= '0;
        msg.byte_present   <= 1'b0;
        msg.end_of_message <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        rst_n              <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        setting = '{pack_text("BAD"), pack_text("abcdefgh"), '0,
                    64'hFFFF_FFFF_FFFF_FF00, pack_text("Q") | 64'hA5A5_0000,
                    64'h0000_0000_0000_00FF, '0, '0};
        write_slots(setting);

        send_word(8'h00, 1'b0, 1'b1);
        send_text("bad", 1'b1);
        send_text("BA", 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_text("D", 1'b1);
        // history is cleared between messages
        send_text("BA", 1'b1);
        send_text("D", 1'b1);
        send_text("ABCDEFGH", 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_text("x", 1'b0);
        send_word("Q", 1'b0, 1'b1);
        send_text("q", 1'b1);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            foreach (setting[i])
            begin
                setting[i] = (p == 0) ? slot_t'('0) : (p == 1) ? slot_t'('1) : make_slot();
            end
            write_slots(setting);
            tx_gaps = (p != QUIET_PHASE);
            rx_gaps = (p != QUIET_PHASE);
            if (p == HOLD_PHASE)
            begin
                hold_token++;
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                send_message(p == HOLD_PHASE ? 2 : 16);
            end
            settle();
        end

        if (board.errors == 0)
        begin
            $display("PASS blocked_word_stream_matcher");
        end
        else
        begin
            $display("FAIL blocked_word_stream_matcher");
        end
        $finish;
    end

endmodule
